[rtl/lrul_pkg.sv]
// ----------------------------------------------------------------------------
// lrul_pkg
// Shared types and constants for the LRU replacement list.
// ----------------------------------------------------------------------------
package lrul_pkg;

  localparam int FIELD_W = 16;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] SLOT_COUNT_RST = CFG_W'(16);

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_ROTATE = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic       evict;
    logic       append;
  } lrul_ctl_t;

endpackage

[rtl/lru_replacement_list_core.sv]
// ----------------------------------------------------------------------------
// lru_replacement_list_core
// Recency-ordered key list with hit, insert and least-recent eviction.
// ----------------------------------------------------------------------------
// Each request is matched against all occupied positions in the cycle it is
// accepted, and the row of cells is updated at that same edge. The list is
// then streamed out least-recent first by rotating the occupied cells one
// position per accepted result; no new request is taken until the last
// entry of the previous list has been accepted.
module lru_replacement_list_core #(
  parameter int SLOTS    = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lrul_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lrul_pkg::FIELD_W-1:0] access_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lrul_pkg::FIELD_W-1:0] list_key,
  output logic                        last_entry,
  output logic                        was_hit,
  output logic                        evicted_valid,
  output logic [lrul_pkg::FIELD_W-1:0] evicted_key
);
  import lrul_pkg::*;

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                st;
  logic [CFG_W-1:0]    slot_count;
  logic [CNT_W-1:0]    fill;
  logic [CNT_W-1:0]    emit_cnt;
  logic [FIELD_W-1:0]  ev_key;

  logic [KEY_BITS-1:0] cell_key [SLOTS];
  logic [SLOTS-1:0]    match;
  logic [SLOTS-1:0]    sh;
  logic [KEY_BITS-1:0] new_key;
  logic [31:0]         in_wide;
  logic [31:0]         head_wide;
  logic [CW-1:0]       cap;
  logic                full;
  logic                hit;
  logic                take;
  logic                give;
  lrul_ctl_t           ctl;

  assign in_wide   = 32'(access_key);
  assign new_key   = in_wide[KEY_BITS-1:0];
  assign head_wide = 32'(cell_key[0]);

  always_comb begin
    if (slot_count == '0) begin
      cap = CW'(1);
    end else if (CW'(slot_count) > CW'(SLOTS)) begin
      cap = CW'(SLOTS);
    end else begin
      cap = CW'(slot_count);
    end
  end

  assign full = CW'(fill) >= cap;
  assign hit  = |match;
  assign take = in_valid && in_ready;
  assign give = out_valid && out_ready;

  always_comb begin
    ctl.evict  = !hit && full;
    ctl.append = !hit && !full;
    if (take) begin
      ctl.op = OP_UPDATE;
    end else if (give) begin
      ctl.op = OP_ROTATE;
    end else begin
      ctl.op = OP_HOLD;
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lrul_cell #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS),
      .IDX      (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .fill      (fill),
      .new_key   (new_key),
      .right_key ((g < SLOTS - 1) ? cell_key[(g + 1) % SLOTS] : cell_key[g]),
      .head_key  (cell_key[0]),
      .shift_in  ((g == 0) ? ctl.evict : sh[(g + SLOTS - 1) % SLOTS]),
      .shift_out (sh[g]),
      .match     (match[g]),
      .key       (cell_key[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      slot_count <= SLOT_COUNT_RST;
      fill       <= '0;
      emit_cnt   <= '0;
    end else begin
      if (cfg_we) begin
        slot_count <= cfg_data;
      end
      case (st)
        ST_IDLE: begin
          if (take) begin
            if (ctl.append) begin
              fill <= fill + CNT_W'(1);
            end
            emit_cnt <= '0;
            st       <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (give) begin
            if (last_entry) begin
              st <= ST_IDLE;
            end else begin
              emit_cnt <= emit_cnt + CNT_W'(1);
            end
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      was_hit       <= hit;
      evicted_valid <= ctl.evict;
      ev_key        <= ctl.evict ? head_wide[FIELD_W-1:0] : '0;
    end
  end

  assign in_ready    = (st == ST_IDLE);
  assign out_valid   = (st == ST_EMIT);
  assign list_key    = head_wide[FIELD_W-1:0];
  assign last_entry  = (emit_cnt + CNT_W'(1)) == fill;
  assign evicted_key = ev_key;

endmodule

[rtl/lrul_cell.sv]
// ----------------------------------------------------------------------------
// lrul_cell
// One list position: holds a key, matches it, and shifts or rotates it.
// ----------------------------------------------------------------------------
module lrul_cell #(
  parameter int SLOTS    = 16,
  parameter int KEY_BITS = 16,
  parameter int IDX      = 0
) (
  input  logic                       clk,
  input  lrul_pkg::lrul_ctl_t        ctl,
  input  logic [$clog2(SLOTS+1)-1:0] fill,
  input  logic [KEY_BITS-1:0]        new_key,
  input  logic [KEY_BITS-1:0]        right_key,
  input  logic [KEY_BITS-1:0]        head_key,
  input  logic                       shift_in,
  output logic                       shift_out,
  output logic                       match,
  output logic [KEY_BITS-1:0]        key
);
  import lrul_pkg::*;

  localparam int CNT_W = $clog2(SLOTS + 1);

  logic occupied;
  logic has_right;
  logic is_newest;
  logic is_next_free;

  assign occupied     = fill > CNT_W'(IDX);
  assign has_right    = fill > CNT_W'(IDX + 1);
  assign is_newest    = fill == CNT_W'(IDX + 1);
  assign is_next_free = fill == CNT_W'(IDX);

  assign match     = occupied && (key == new_key);
  assign shift_out = shift_in | match;

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_UPDATE: begin
        if (ctl.append) begin
          if (is_next_free) begin
            key <= new_key;
          end
        end else if (shift_out) begin
          if (has_right) begin
            key <= right_key;
          end else if (is_newest) begin
            key <= new_key;
          end
        end
      end
      OP_ROTATE: begin
        if (has_right) begin
          key <= right_key;
        end else if (is_newest) begin
          key <= head_key;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Checks lru_replacement_list_core. Each accepted request is run through a
// local recency list that predicts the full least-to-most-recent listing.
// Every result is then compared against the oldest predicted entry. The run
// covers several slot counts, random sender and receiver gaps, a long sink
// hold-off and a sender that pauses until the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

  import lrul_pkg::*;

  localparam int SLOTS     = 16;
  localparam int POOL_SIZE = 32;

  typedef struct packed {
    logic [FIELD_W-1:0] key;
    logic               newest;
    logic               hit;
    logic               ev_valid;
    logic [FIELD_W-1:0] ev_key;
  } list_entry_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [CFG_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [FIELD_W-1:0] access_key;
  logic               out_valid;
  logic               out_ready;
  logic [FIELD_W-1:0] list_key;
  logic               last_entry;
  logic               was_hit;
  logic               evicted_valid;
  logic [FIELD_W-1:0] evicted_key;

  // predicted state
  logic [FIELD_W-1:0] lru_keys [SLOTS];
  int                 fill_cnt;
  logic [CFG_W-1:0]   slot_cfg;

  list_entry_t        listing_q [$];
  logic [FIELD_W-1:0] key_pool [POOL_SIZE];
  int unsigned        err_cnt;
  int unsigned        sink_hold;
  int unsigned        sink_stall;
  bit                 idle_on;

  lru_replacement_list_core #(
    .SLOTS    (SLOTS),
    .KEY_BITS (16)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .access_key    (access_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .list_key      (list_key),
    .last_entry    (last_entry),
    .was_hit       (was_hit),
    .evicted_valid (evicted_valid),
    .evicted_key   (evicted_key)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(2000000);
    $display("status: fail");
    $finish;
  end

  // ---- prediction ----

  task automatic predict_access(input logic [FIELD_W-1:0] key);
    int          cap;
    int          pos;
    int          i;
    bit          hit;
    bit          evict;
    logic [FIELD_W-1:0] ev_key;
    list_entry_t ent;
    cap    = (slot_cfg == '0) ? 1 : ((int'(slot_cfg) > SLOTS) ? SLOTS : int'(slot_cfg));
    hit    = 1'b0;
    evict  = 1'b0;
    pos    = 0;
    ev_key = '0;
    for (i = 0; i < fill_cnt; i++) begin
      if (!hit && lru_keys[i] == key) begin
        hit = 1'b1;
        pos = i;
      end
    end
    if (!hit && fill_cnt < cap) begin
      lru_keys[fill_cnt] = key;
      fill_cnt++;
    end else begin
      if (!hit) begin
        evict  = 1'b1;
        ev_key = lru_keys[0];
      end
      for (i = pos; i + 1 < fill_cnt; i++) lru_keys[i] = lru_keys[i+1];
      lru_keys[fill_cnt-1] = key;
    end
    for (i = 0; i < fill_cnt; i++) begin
      ent.key      = lru_keys[i];
      ent.newest   = (i + 1 == fill_cnt);
      ent.hit      = hit;
      ent.ev_valid = evict;
      ent.ev_key   = ev_key;
      listing_q.push_back(ent);
    end
  endtask

  // ---- driving ----

  task automatic send_access(input logic [FIELD_W-1:0] key);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    access_key <= key;
    do @(posedge clk); while (!in_ready);
    predict_access(key);
  endtask

  task automatic wait_for_lists();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (listing_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SLOTS + 4) @(posedge clk);
  endtask

  task automatic write_slot_count(input logic [CFG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    slot_cfg = value;
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [FIELD_W-1:0] pick_key(input int span);
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, span - 1)];
    return FIELD_W'($urandom);
  endfunction

  // ---- sink ----

  initial begin
    out_ready  <= 1'b0;
    sink_stall = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sink_stall = idle_on ? $urandom_range(0, 7) : 0;
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---- checking ----

  always @(posedge clk) begin : check_listing
    list_entry_t want;
    list_entry_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{list_key, last_entry, was_hit, evicted_valid, evicted_key};
      if (listing_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected entry: key=%h last=%b hit=%b ev=%b/%h",
                                    got.key, got.newest, got.hit, got.ev_valid, got.ev_key);
      end else begin
        want = listing_q.pop_front();
        if (got.key !== want.key || got.newest !== want.newest || got.hit !== want.hit ||
            got.ev_valid !== want.ev_valid || got.ev_key !== want.ev_key) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch: exp key=%h last=%b hit=%b ev=%b/%h", want.key, want.newest,
                     want.hit, want.ev_valid, want.ev_key);
            $display("          got key=%h last=%b hit=%b ev=%b/%h", got.key, got.newest,
                     got.hit, got.ev_valid, got.ev_key);
          end
        end
      end
    end
  end

  // ---- tests ----

  // slot count 0 acts as one slot; key extremes
  task automatic test_single_slot();
    int n;
    write_slot_count(CFG_W'(0));
    send_access(16'h0000);
    send_access(16'hFFFF);
    send_access(16'hFFFF);
    send_access(16'h1234);
    wait_for_lists();
    write_slot_count(CFG_W'(1));
    for (n = 0; n < 6; n++) send_access(pick_key(3));
    wait_for_lists();
  endtask

  task automatic test_small_fill();
    int n;
    write_slot_count(CFG_W'(3));
    for (n = 0; n < 10; n++) send_access(pick_key(5));
    wait_for_lists();
  endtask

  // count below fill: list keeps its length, misses still evict
  task automatic test_lowered_count();
    int n;
    write_slot_count(CFG_W'(2));
    send_access(lru_keys[0]);
    send_access(16'hA5A5);
    send_access(lru_keys[1]);
    for (n = 0; n < 7; n++) send_access(pick_key(5));
    wait_for_lists();
  endtask

  task automatic test_mid_fill();
    int n;
    idle_on = 1'b0;
    write_slot_count(CFG_W'(8));
    for (n = 0; n < 20; n++) send_access(pick_key(12));
    wait_for_lists();
    idle_on = 1'b1;
  endtask

  // values above the built slot count clamp to it
  task automatic test_clamped_count();
    int n;
    write_slot_count(CFG_W'(31));
    for (n = 0; n < 30; n++) send_access(pick_key(POOL_SIZE));
    wait_for_lists();
  endtask

  task automatic test_hit_positions();
    send_access(lru_keys[0]);
    send_access(lru_keys[fill_cnt-1]);
    send_access(lru_keys[fill_cnt/2]);
    send_access(16'hFFFF);
    send_access(16'h0000);
    wait_for_lists();
  endtask

  task automatic test_sink_holdoff();
    int n;
    sink_hold = 80;
    for (n = 0; n < 12; n++) send_access(pick_key(POOL_SIZE));
    wait_for_lists();
  endtask

  task automatic test_sender_pause();
    int n;
    for (n = 0; n < 6; n++) begin
      send_access(pick_key(POOL_SIZE));
      wait_for_lists();
    end
  endtask

  task automatic test_random_access();
    int n;
    write_slot_count(CFG_W'(16));
    for (n = 0; n < 90; n++) begin
      if (n % 30 == 0) idle_on = (n != 30);
      send_access(pick_key((n < 45) ? 20 : POOL_SIZE));
    end
    wait_for_lists();
    idle_on = 1'b1;
  endtask

  initial begin
    int i;
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    access_key <= '0;
    err_cnt    = 0;
    sink_hold  = 0;
    idle_on    = 1'b1;
    fill_cnt   = 0;
    slot_cfg   = SLOT_COUNT_RST;
    for (i = 0; i < SLOTS; i++) lru_keys[i] = '0;
    for (i = 0; i < POOL_SIZE; i++) key_pool[i] = FIELD_W'($urandom);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_single_slot();
    test_small_fill();
    test_lowered_count();
    test_mid_fill();
    test_clamped_count();
    test_hit_positions();
    test_sink_holdoff();
    test_sender_pause();
    test_random_access();

    wait_for_lists();
    if (err_cnt == 0 && listing_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/lrul_pkg.sv
rtl/lrul_cell.sv
rtl/lru_replacement_list_core.sv
verif/tb_top.sv
